>>> rtl/core/sorted_table_insert_delete_lookup_assert.svh
// Assertion macros used by the table RTL.
`ifndef SORTED_TABLE_INSERT_DELETE_LOOKUP_ASSERT_SVH
`define SORTED_TABLE_INSERT_DELETE_LOOKUP_ASSERT_SVH

// Same-cycle implication.
`define STBL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("table assertion failed");

// Next-cycle implication.
`define STBL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("table assertion failed");

`endif

>>> rtl/core/stbl_pkg.sv
package stbl_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int KEY_BITS    = 16;
    localparam int VALUE_BITS  = 32;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_DELETE   = 2'd1;
    localparam logic [1:0] OP_RETRIEVE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MISSING = 2'd2;

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;

    typedef struct packed {
        logic ins;
        logic del;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_APPLY = 2'b10
    } t_state;

endpackage

>>> rtl/core/stbl_cell.sv
module stbl_cell (
    input  logic                     i_clk,
    input  logic [stbl_pkg::IDX_W-1:0] i_index,
    input  logic [stbl_pkg::CNT_W-1:0] i_count,
    input  logic                     i_load,
    input  stbl_pkg::t_key           i_cmp_key,
    input  stbl_pkg::t_cell_ctl      i_ctl,
    input  stbl_pkg::t_key           i_new_key,
    input  stbl_pkg::t_value         i_new_value,
    input  logic                     i_left_lt,
    input  stbl_pkg::t_key           i_left_key,
    input  stbl_pkg::t_value         i_left_value,
    input  stbl_pkg::t_key           i_right_key,
    input  stbl_pkg::t_value         i_right_value,
    output stbl_pkg::t_key           o_key,
    output stbl_pkg::t_value         o_value,
    output logic                     o_lt,
    output logic                     o_hit
);

    stbl_pkg::t_key   r_key,   n_key;
    stbl_pkg::t_value r_value, n_value;
    logic             r_lt, r_eq, r_held;
    logic             w_spot;
    logic             w_held;

    assign w_held = {1'b0, i_index} < i_count;
    assign w_spot = !r_lt && i_left_lt;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (!r_lt) begin
            if (i_ctl.ins) begin
                if (i_left_lt) begin
                    n_key   = i_new_key;
                    n_value = i_new_value;
                end else begin
                    n_key   = i_left_key;
                    n_value = i_left_value;
                end
            end else if (i_ctl.del) begin
                n_key   = i_right_key;
                n_value = i_right_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
        if (i_load) begin
            r_held <= w_held;
            r_lt   <= w_held && (r_key < i_cmp_key);
            r_eq   <= r_key == i_cmp_key;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_hit   = w_spot && r_eq && r_held;

endmodule

>>> rtl/core/sorted_table_insert_delete_lookup.sv
// Sorted key/value table, up to TABLE_DEPTH entries in ascending key order.
// Request channel: i_op, i_key, i_item_value are taken at a rising edge with
// start high and busy low. Ops: insert, delete (first matching key), retrieve
// (value of first matching key). Duplicate keys are kept.
// Result channel: o_status, o_value_out, o_fill_count are valid for exactly
// one cycle while o_done is high; there is no backpressure.
// Each entry lives in one cell of a row; all cells compare against the key in
// the accept cycle, and in the next cycle each cell keeps its entry, takes the
// new entry or takes its left or right neighbor's, so inserts and deletes shift
// the row from the matching spot onward in one step.
// Sequence: the request is accepted in S_IDLE, the row shifts in S_APPLY, and
// o_done and the result are registered at the end of S_APPLY.
// busy is high in S_APPLY, the state after acceptance, at whose end the row shifts;
// no new request is taken while busy is high.
// Reset (synchronous, i_rst_n low) empties the table and clears busy and
// o_done; entry storage is not cleared, no clearing pass is needed.
module sorted_table_insert_delete_lookup (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [15:0] i_key,
    input  logic [31:0] i_item_value,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [31:0] o_value_out,
    output logic [4:0]  o_fill_count
);

`include "sorted_table_insert_delete_lookup_assert.svh"

    localparam int D = stbl_pkg::TABLE_DEPTH;

    stbl_pkg::t_state    r_state;
    logic [1:0]          r_op;
    stbl_pkg::t_key      r_key;
    stbl_pkg::t_value    r_value;
    logic [stbl_pkg::CNT_W-1:0] r_count, n_count;
    logic                w_accept;
    logic                w_apply;
    logic                w_full;
    logic                w_found;
    stbl_pkg::t_value    w_found_value;
    logic [1:0]          n_status;
    stbl_pkg::t_value    n_value_out;
    stbl_pkg::t_cell_ctl w_ctl;

    stbl_pkg::t_key   w_cell_key   [D];
    stbl_pkg::t_value w_cell_value [D];
    logic [D-1:0]     w_lt;
    logic [D-1:0]     w_hit;

    assign busy     = r_state == stbl_pkg::S_APPLY;
    assign w_accept = start && !busy;
    assign w_apply  = r_state == stbl_pkg::S_APPLY;
    assign w_full   = r_count == stbl_pkg::CNT_W'(D);
    assign w_found  = |w_hit;

    always_comb begin
        w_found_value = '0;
        for (int i = 0; i < D; i++) begin
            if (w_hit[i]) begin
                w_found_value = w_found_value | w_cell_value[i];
            end
        end
    end

    always_comb begin
        w_ctl.ins   = w_apply && r_op == stbl_pkg::OP_INSERT && !w_full;
        w_ctl.del   = w_apply && r_op == stbl_pkg::OP_DELETE && w_found;
        n_count     = r_count;
        n_status    = stbl_pkg::ST_OK;
        n_value_out = '0;
        case (r_op)
            stbl_pkg::OP_INSERT: begin
                if (w_full) begin
                    n_status = stbl_pkg::ST_FULL;
                end else begin
                    n_count = r_count + stbl_pkg::CNT_W'(1);
                end
            end
            stbl_pkg::OP_DELETE: begin
                if (w_found) begin
                    n_count = r_count - stbl_pkg::CNT_W'(1);
                end else begin
                    n_status = stbl_pkg::ST_MISSING;
                end
            end
            stbl_pkg::OP_RETRIEVE: begin
                if (w_found) begin
                    n_value_out = w_found_value;
                end else begin
                    n_status = stbl_pkg::ST_MISSING;
                end
            end
            default: begin
                n_status = stbl_pkg::ST_OK;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < D; g++) begin : g_cell
            logic             w_left_lt;
            stbl_pkg::t_key   w_left_key, w_right_key;
            stbl_pkg::t_value w_left_value, w_right_value;
            if (g == 0) begin : g_first
                assign w_left_lt    = 1'b1;
                assign w_left_key   = r_key;
                assign w_left_value = r_value;
            end else begin : g_mid
                assign w_left_lt    = w_lt[g-1];
                assign w_left_key   = w_cell_key[g-1];
                assign w_left_value = w_cell_value[g-1];
            end
            if (g == D - 1) begin : g_last
                assign w_right_key   = w_cell_key[g];
                assign w_right_value = w_cell_value[g];
            end else begin : g_inner
                assign w_right_key   = w_cell_key[g+1];
                assign w_right_value = w_cell_value[g+1];
            end
            stbl_cell u_cell (
                .i_clk         (i_clk),
                .i_index       (stbl_pkg::IDX_W'(g)),
                .i_count       (r_count),
                .i_load        (w_accept),
                .i_cmp_key     (i_key),
                .i_ctl         (w_ctl),
                .i_new_key     (r_key),
                .i_new_value   (r_value),
                .i_left_lt     (w_left_lt),
                .i_left_key    (w_left_key),
                .i_left_value  (w_left_value),
                .i_right_key   (w_right_key),
                .i_right_value (w_right_value),
                .o_key         (w_cell_key[g]),
                .o_value       (w_cell_value[g]),
                .o_lt          (w_lt[g]),
                .o_hit         (w_hit[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_item_value;
        end
        o_status     <= n_status;
        o_value_out  <= n_value_out;
        o_fill_count <= n_count;
        if (!i_rst_n) begin
            r_state <= stbl_pkg::S_IDLE;
            r_count <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= w_apply;
            case (r_state)
                stbl_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_state <= stbl_pkg::S_APPLY;
                    end
                end
                stbl_pkg::S_APPLY: begin
                    r_state <= stbl_pkg::S_IDLE;
                    r_count <= n_count;
                end
                default: begin
                    r_state <= stbl_pkg::S_IDLE;
                end
            endcase
        end
    end

    `STBL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= stbl_pkg::CNT_W'(D))
    `STBL_ASSERT_NEXT(a_apply_done, i_clk, i_rst_n, w_apply, o_done)
    `STBL_ASSERT_NOW(a_done_not_busy, i_clk, i_rst_n, o_done, !busy)
    `STBL_ASSERT_NOW(a_single_hit, i_clk, i_rst_n, w_apply, $onehot0(w_hit))

endmodule
